// ===== sv/sci_pkg.sv =====
package sci_pkg;

   localparam int CoordWidthDefault = 16;

   typedef struct packed {
      logic a_pos;
      logic c_pos;
      logic t1;
      logic t2;
   } sci_flags_type;

endpackage

// ===== sv/segment_circle_intersect.sv =====
// Exact segment/circle boundary test, fully pipelined: a new word may be started
// every cycle and busy is never raised. Each word passes through the pipeline
// stages in order (differences, products, coefficients, root tests, split
// discriminant products, recombine, decision). The result is shown on
// rsp_strobe/rsp_hit for one cycle only and cannot be held off, so the
// receiver must take it when it appears.
module segment_circle_intersect
   import sci_pkg::*;
#(
   parameter int COORD_WIDTH = CoordWidthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_centre_x,
   input  logic signed [COORD_WIDTH-1:0] req_centre_y,
   input  logic        [COORD_WIDTH-1:0] req_circle_radius,
   output logic                          rsp_strobe,
   output logic                          rsp_hit
);

   localparam int Latency = 7;
   localparam int W       = COORD_WIDTH;

   logic                 accept;
   logic                 prod_valid, coef_valid;
   logic signed [2*W+1:0] dxx, dyy, fxdx, fydy, fxx, fyy;
   logic        [2*W-1:0] rr;
   sci_flags_type        flags;
   logic        [2*W+1:0] a_mag, h_mag, c_mag;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   sci_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock         (clock),
      .reset         (reset),
      .valid         (accept),
      .start_x       (req_start_x),
      .start_y       (req_start_y),
      .end_x         (req_end_x),
      .end_y         (req_end_y),
      .centre_x      (req_centre_x),
      .centre_y      (req_centre_y),
      .circle_radius (req_circle_radius),
      .prod_valid    (prod_valid),
      .dxx           (dxx),
      .dyy           (dyy),
      .fxdx          (fxdx),
      .fydy          (fydy),
      .fxx           (fxx),
      .fyy           (fyy),
      .rr            (rr)
   );

   sci_coef #(.COORD_WIDTH(COORD_WIDTH)) u_coef (
      .clock      (clock),
      .reset      (reset),
      .prod_valid (prod_valid),
      .dxx        (dxx),
      .dyy        (dyy),
      .fxdx       (fxdx),
      .fydy       (fydy),
      .fxx        (fxx),
      .fyy        (fyy),
      .rr         (rr),
      .coef_valid (coef_valid),
      .flags      (flags),
      .a_mag      (a_mag),
      .h_mag      (h_mag),
      .c_mag      (c_mag)
   );

   sci_disc #(.COORD_WIDTH(COORD_WIDTH)) u_disc (
      .clock      (clock),
      .reset      (reset),
      .coef_valid (coef_valid),
      .flags      (flags),
      .a_mag      (a_mag),
      .h_mag      (h_mag),
      .c_mag      (c_mag),
      .hit_valid  (rsp_strobe),
      .hit        (rsp_hit)
   );

   // every strobe traces back to a started word
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, Latency))
      else $error("result strobe without a started word");

   // a started word always comes out
   assert property (@(posedge clock) disable iff (reset)
      accept |-> ##Latency rsp_strobe)
      else $error("started word lost in pipeline");

   // zero-length segment never hits
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_start_x == req_end_x) && (req_start_y == req_end_y))
      |-> ##Latency !rsp_hit)
      else $error("hit reported for zero-length segment");

endmodule

// ===== sv/sci_front.sv =====
module sci_front
   import sci_pkg::*;
#(
   parameter int COORD_WIDTH = CoordWidthDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  valid,
   input  logic signed [COORD_WIDTH-1:0]         start_x,
   input  logic signed [COORD_WIDTH-1:0]         start_y,
   input  logic signed [COORD_WIDTH-1:0]         end_x,
   input  logic signed [COORD_WIDTH-1:0]         end_y,
   input  logic signed [COORD_WIDTH-1:0]         centre_x,
   input  logic signed [COORD_WIDTH-1:0]         centre_y,
   input  logic        [COORD_WIDTH-1:0]         circle_radius,
   output logic                                  prod_valid,
   output logic signed [2*COORD_WIDTH+1:0]       dxx,
   output logic signed [2*COORD_WIDTH+1:0]       dyy,
   output logic signed [2*COORD_WIDTH+1:0]       fxdx,
   output logic signed [2*COORD_WIDTH+1:0]       fydy,
   output logic signed [2*COORD_WIDTH+1:0]       fxx,
   output logic signed [2*COORD_WIDTH+1:0]       fyy,
   output logic        [2*COORD_WIDTH-1:0]       rr
);

   localparam int W = COORD_WIDTH;
   localparam int D = W + 1;
   localparam int P = 2 * D;

   logic              v1_ff, v2_ff;
   logic signed [D-1:0] dx_in, dy_in, fx_in, fy_in;
   logic signed [D-1:0] dx_ff, dy_ff, fx_ff, fy_ff;
   logic [W-1:0]        r_ff;
   logic signed [P-1:0] dxx_in, dyy_in, fxdx_in, fydy_in, fxx_in, fyy_in;
   logic signed [P-1:0] dxx_ff, dyy_ff, fxdx_ff, fydy_ff, fxx_ff, fyy_ff;
   logic [2*W-1:0]      rr_in, rr_ff;

   // stage 1: differences
   assign dx_in = $signed({end_x[W-1], end_x}) - $signed({start_x[W-1], start_x});
   assign dy_in = $signed({end_y[W-1], end_y}) - $signed({start_y[W-1], start_y});
   assign fx_in = $signed({start_x[W-1], start_x}) - $signed({centre_x[W-1], centre_x});
   assign fy_in = $signed({start_y[W-1], start_y}) - $signed({centre_y[W-1], centre_y});

   // stage 2: products
   assign dxx_in  = P'(dx_ff) * P'(dx_ff);
   assign dyy_in  = P'(dy_ff) * P'(dy_ff);
   assign fxdx_in = P'(fx_ff) * P'(dx_ff);
   assign fydy_in = P'(fy_ff) * P'(dy_ff);
   assign fxx_in  = P'(fx_ff) * P'(fx_ff);
   assign fyy_in  = P'(fy_ff) * P'(fy_ff);
   assign rr_in   = (2 * W)'(r_ff) * (2 * W)'(r_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      fx_ff   <= fx_in;
      fy_ff   <= fy_in;
      r_ff    <= circle_radius;
      dxx_ff  <= dxx_in;
      dyy_ff  <= dyy_in;
      fxdx_ff <= fxdx_in;
      fydy_ff <= fydy_in;
      fxx_ff  <= fxx_in;
      fyy_ff  <= fyy_in;
      rr_ff   <= rr_in;
   end

   assign prod_valid = v2_ff;
   assign dxx        = dxx_ff;
   assign dyy        = dyy_ff;
   assign fxdx       = fxdx_ff;
   assign fydy       = fydy_ff;
   assign fxx        = fxx_ff;
   assign fyy        = fyy_ff;
   assign rr         = rr_ff;

endmodule

// ===== sv/sci_coef.sv =====
module sci_coef
   import sci_pkg::*;
#(
   parameter int COORD_WIDTH = CoordWidthDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            prod_valid,
   input  logic signed [2*COORD_WIDTH+1:0] dxx,
   input  logic signed [2*COORD_WIDTH+1:0] dyy,
   input  logic signed [2*COORD_WIDTH+1:0] fxdx,
   input  logic signed [2*COORD_WIDTH+1:0] fydy,
   input  logic signed [2*COORD_WIDTH+1:0] fxx,
   input  logic signed [2*COORD_WIDTH+1:0] fyy,
   input  logic        [2*COORD_WIDTH-1:0] rr,
   output logic                            coef_valid,
   output sci_flags_type                   flags,
   output logic        [2*COORD_WIDTH+1:0] a_mag,
   output logic        [2*COORD_WIDTH+1:0] h_mag,
   output logic        [2*COORD_WIDTH+1:0] c_mag
);

   localparam int W = COORD_WIDTH;
   localparam int S = 2 * W + 4;
   localparam int M = 2 * W + 2;

   logic                v3_ff, v4_ff;
   logic signed [S-1:0] a_in, h_in, c_in;
   logic signed [S-1:0] a_ff, h_ff, c_ff;
   logic signed [S-1:0] ah_sum, g_sum, h_neg;
   logic                h_le0, c_le0;
   sci_flags_type       flags_in, flags_ff;
   logic [M-1:0]        a_mag_ff, h_mag_in, h_mag_ff, c_mag_ff;

   // stage 3: quadratic coefficients, b = 2h
   assign a_in = S'(dxx) + S'(dyy);
   assign h_in = S'(fxdx) + S'(fydy);
   assign c_in = S'(fxx) + S'(fyy) - $signed({{(S - 2 * W){1'b0}}, rr});

   // stage 4: root position tests by sign, magnitudes for the discriminant
   assign ah_sum = a_ff + h_ff;
   assign g_sum  = ah_sum + h_ff + c_ff;
   assign h_neg  = -h_ff;
   assign h_le0  = h_ff[S-1] || (h_ff == '0);
   assign c_le0  = c_ff[S-1] || (c_ff == '0);

   always_comb begin
      flags_in.a_pos = (a_ff != '0);
      flags_in.c_pos = !c_le0;
      flags_in.t2    = (h_le0 || c_le0) && !ah_sum[S-1] && !g_sum[S-1];
      flags_in.t1    = h_le0 && !c_ff[S-1] &&
                       (!ah_sum[S-1] || g_sum[S-1] || (g_sum == '0));
   end

   assign h_mag_in = h_ff[S-1] ? h_neg[M-1:0] : h_ff[M-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v3_ff <= prod_valid;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      h_ff     <= h_in;
      c_ff     <= c_in;
      flags_ff <= flags_in;
      a_mag_ff <= a_ff[M-1:0];
      h_mag_ff <= h_mag_in;
      c_mag_ff <= c_ff[M-1:0];
   end

   assign coef_valid = v4_ff;
   assign flags      = flags_ff;
   assign a_mag      = a_mag_ff;
   assign h_mag      = h_mag_ff;
   assign c_mag      = c_mag_ff;

endmodule

// ===== sv/sci_disc.sv =====
module sci_disc
   import sci_pkg::*;
#(
   parameter int COORD_WIDTH = CoordWidthDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     coef_valid,
   input  sci_flags_type            flags,
   input  logic [2*COORD_WIDTH+1:0] a_mag,
   input  logic [2*COORD_WIDTH+1:0] h_mag,
   input  logic [2*COORD_WIDTH+1:0] c_mag,
   output logic                     hit_valid,
   output logic                     hit
);

   localparam int M = 2 * COORD_WIDTH + 2;
   localparam int L = M / 2;
   localparam int H = M - L;
   localparam int Q = 2 * M;

   logic              v5_ff, v6_ff, v7_ff;
   sci_flags_type     f5_ff, f6_ff;
   logic [L-1:0]      al, hl, cl;
   logic [H-1:0]      ahi, hhi, chi;
   // partial products of h*h and a*c
   logic [2*L-1:0]    hll_in, hll_ff, all_in, all_ff;
   logic [L+H-1:0]    hx_in, hx_ff, alh_in, alh_ff, ahl_in, ahl_ff;
   logic [2*H-1:0]    hhh_in, hhh_ff, ahh_in, ahh_ff;
   logic [Q-1:0]      sq_in, sq_ff, ac_in, ac_ff;
   logic              hit_in, hit_ff;

   assign al  = a_mag[L-1:0];
   assign ahi = a_mag[M-1:L];
   assign hl  = h_mag[L-1:0];
   assign hhi = h_mag[M-1:L];
   assign cl  = c_mag[L-1:0];
   assign chi = c_mag[M-1:L];

   // stage 5: half-width products
   assign hll_in = (2 * L)'(hl) * (2 * L)'(hl);
   assign hx_in  = (L + H)'(hl) * (L + H)'(hhi);
   assign hhh_in = (2 * H)'(hhi) * (2 * H)'(hhi);
   assign all_in = (2 * L)'(al) * (2 * L)'(cl);
   assign alh_in = (L + H)'(al) * (L + H)'(chi);
   assign ahl_in = (L + H)'(ahi) * (L + H)'(cl);
   assign ahh_in = (2 * H)'(ahi) * (2 * H)'(chi);

   // stage 6: recombine
   assign sq_in = {hhh_ff, hll_ff} + (Q'(hx_ff) << (L + 1));
   assign ac_in = {ahh_ff, all_ff} + (Q'(alh_ff) << L) + (Q'(ahl_ff) << L);

   // stage 7: discriminant sign and final decision
   assign hit_in = f6_ff.a_pos && (!f6_ff.c_pos || (sq_ff >= ac_ff)) &&
                   (f6_ff.t1 || f6_ff.t2);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v5_ff <= coef_valid;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      f5_ff  <= flags;
      hll_ff <= hll_in;
      hx_ff  <= hx_in;
      hhh_ff <= hhh_in;
      all_ff <= all_in;
      alh_ff <= alh_in;
      ahl_ff <= ahl_in;
      ahh_ff <= ahh_in;
      f6_ff  <= f5_ff;
      sq_ff  <= sq_in;
      ac_ff  <= ac_in;
      hit_ff <= hit_in;
   end

   assign hit_valid = v7_ff;
   assign hit       = hit_ff;

endmodule
